// ===== rtl/dkr_pkg.sv =====
// shared types, constants and keymap defaults for the debounced key scan reporter
`timescale 1ns / 1ps
package dkr_pkg;

   localparam int DEF_KEY_COUNT        = 13;
   localparam int DEF_DEBOUNCE_SAMPLES = 50;
   localparam int DEF_LAYOUT_COUNT     = 4;

   localparam int LINE_WIDTH  = 13;
   localparam int KEY_OUT_W   = 4;
   localparam int CODE_W      = 8;
   localparam int MAP_ADDR_W  = 8;

   localparam logic [7:0]        IDLE_STEP     = 8'd5;
   localparam logic [CODE_W-1:0] FALLBACK_CODE = 8'd4;
   localparam logic [CODE_W-1:0] FIRST_KEY_BASE = 8'd30;
   localparam logic [CODE_W-1:0] OTHER_KEY_CODE = 8'd41;
   localparam logic [CODE_W-1:0] BASE_CODE [7] = '{8'd0, 8'd15, 8'd4, 8'd28, 8'd18, 8'd24, 8'd23};

   localparam logic FUNC_SCAN      = 1'b0;
   localparam logic FUNC_MAP_WRITE = 1'b1;

   localparam logic CSR_IDLE_RATE  = 1'b0;
   localparam logic CSR_LAYOUT_SEL = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [LINE_WIDTH-1:0] key_lines;
      logic                  timer_tick;
      logic                  host_ready;
      logic [1:0]            map_layout;
      logic [3:0]            map_key;
      logic [CODE_W-1:0]     map_code;
   } req_type;

   typedef struct packed {
      logic [KEY_OUT_W-1:0] key_index;
      logic [CODE_W-1:0]    usage_code;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic                  use_map;
      logic [MAP_ADDR_W-1:0] addr;
      logic [CODE_W-1:0]     wr_code;
      logic [CODE_W-1:0]     alt_code;
   } map_access_type;

   function automatic logic [CODE_W-1:0] default_code(input int layout_idx, input int key_idx);
      logic [CODE_W-1:0] code;
      if (key_idx == 0) begin
         code = FIRST_KEY_BASE + CODE_W'(layout_idx);
      end else if (key_idx < 7) begin
         code = BASE_CODE[key_idx];
      end else begin
         code = OTHER_KEY_CODE;
      end
      return code;
   endfunction

endpackage

// ===== rtl/debounced_key_scan_reporter_unit.sv =====
// top level of the debounced key scan reporter
// Usage: each request on req_* is either a scan cycle carrying the active-low
// key line samples, timer tick and host ready flag, or a keymap entry write.
// A scan request yields zero or one report on rsp_* (key number and usage
// code); a keymap write yields none. csr_* writes idle_rate (index 0) and
// the layout select (index 1); the user must write them only while the block is idle, which the block does not enforce.
// Pipeline: an accepted request is registered with the lane counters; the merge
// stage then feeds the keymap read and the output register together.
// Throughput: one request per cycle unless a held report stalls it; every lane
// counter updates in the cycle its scan request is taken and the merge stage keeps pace.
// Reset: counters, last key, pending flag and idle countdown clear, idle_rate
// goes to 0, the layout select to 1 and the keymap reads its default layouts.
// Stall: while rsp_stall holds a waiting report, the whole pipeline holds and
// req_stall is raised; otherwise a new request enters while the report leaves.
`timescale 1ns / 1ps
module debounced_key_scan_reporter_unit
   import dkr_pkg::*;
#(
   parameter int KEY_COUNT        = DEF_KEY_COUNT,
   parameter int DEBOUNCE_SAMPLES = DEF_DEBOUNCE_SAMPLES,
   parameter int LAYOUT_COUNT     = DEF_LAYOUT_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int KEY_W = $clog2(KEY_COUNT + 1);

   logic                 advance;
   logic                 accept;
   logic                 lane_update;
   logic [KEY_COUNT-1:0] pressed;
   logic                 s1_valid_ff;
   req_type              s1_req_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [KEY_W-1:0]     out_key_ff;
   logic [7:0]           idle_rate_ff;
   logic [2:0]           layout_sel_ff;
   logic                 emit;
   logic [KEY_W-1:0]     key_cur;
   map_access_type       map_access;
   logic [CODE_W-1:0]    usage_code;

   assign advance     = !(out_valid_ff && rsp_stall);
   assign req_stall   = !advance;
   assign accept      = req_valid && advance;
   assign lane_update = accept && (req_data.func == FUNC_SCAN);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_rate_ff  <= '0;
         layout_sel_ff <= 3'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IDLE_RATE: begin
               idle_rate_ff <= csr_wdata;
            end
            CSR_LAYOUT_SEL: begin
               layout_sel_ff <= csr_wdata[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
      logic sample_low;
      if (i < LINE_WIDTH) begin : g_line
         assign sample_low = !req_data.key_lines[i];
      end else begin : g_no_line
         assign sample_low = 1'b0;
      end
      dkr_lane #(
         .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .update_en (lane_update),
         .sample_low(sample_low),
         .pressed   (pressed[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
   end

   dkr_report #(
      .KEY_COUNT   (KEY_COUNT),
      .LAYOUT_COUNT(LAYOUT_COUNT)
   ) u_report (
      .clock     (clock),
      .reset     (reset),
      .commit_en (advance && s1_valid_ff),
      .req_s1    (s1_req_ff),
      .pressed   (pressed),
      .idle_rate (idle_rate_ff),
      .layout_sel(layout_sel_ff),
      .emit      (emit),
      .key_cur   (key_cur),
      .map_access(map_access)
   );

   dkr_keymap #(
      .KEY_COUNT   (KEY_COUNT),
      .LAYOUT_COUNT(LAYOUT_COUNT)
   ) u_keymap (
      .clock     (clock),
      .reset     (reset),
      .map_access(map_access),
      .usage_code(usage_code)
   );

   assign out_valid_in = s1_valid_ff && (s1_req_ff.func == FUNC_SCAN) && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_key_ff <= key_cur;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_data.key_index  = KEY_OUT_W'(out_key_ff);
   assign rsp_data.usage_code = usage_code;

endmodule

// ===== rtl/dkr_lane.sv =====
// one key lane: saturating count of consecutive low samples
`timescale 1ns / 1ps
module dkr_lane
   import dkr_pkg::*;
#(
   parameter int DEBOUNCE_SAMPLES = DEF_DEBOUNCE_SAMPLES
) (
   input  logic clock,
   input  logic reset,
   input  logic update_en,
   input  logic sample_low,
   output logic pressed
);

   localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEBOUNCE_SAMPLES);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      if (!sample_low) begin
         count_in = '0;
      end else if (count_ff < CNT_MAX) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (update_en) begin
         count_ff <= count_in;
      end
   end

   assign pressed = (count_ff == CNT_MAX);

endmodule

// ===== rtl/dkr_report.sv =====
// merge stage: key priority, change detect, idle repeat timer and report decision
`timescale 1ns / 1ps
module dkr_report
   import dkr_pkg::*;
#(
   parameter int KEY_COUNT    = DEF_KEY_COUNT,
   parameter int LAYOUT_COUNT = DEF_LAYOUT_COUNT,
   localparam int KEY_W       = $clog2(KEY_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 commit_en,
   input  req_type              req_s1,
   input  logic [KEY_COUNT-1:0] pressed,
   input  logic [7:0]           idle_rate,
   input  logic [2:0]           layout_sel,
   output logic                 emit,
   output logic [KEY_W-1:0]     key_cur,
   output map_access_type       map_access
);

   logic [KEY_W-1:0] last_key_ff;
   logic [KEY_W-1:0] last_key_in;
   logic             pending_ff;
   logic             pending_in;
   logic [7:0]       countdown_ff;
   logic [7:0]       countdown_in;
   logic             scan_commit;
   logic             pend_key;
   logic             pend_all;
   logic             lay_ok;
   logic             map_wr_ok;

   always_comb begin
      key_cur = '0;
      for (int k = 3; k >= 1; k--) begin
         if (k <= KEY_COUNT) begin
            if (pressed[k-1]) begin
               key_cur = KEY_W'(k);
            end
         end
      end
      for (int k = KEY_COUNT; k >= 4; k--) begin
         if (pressed[k-1]) begin
            key_cur = KEY_W'(k);
         end
      end
   end

   assign scan_commit = commit_en && (req_s1.func == FUNC_SCAN);
   assign pend_key    = pending_ff || (key_cur != last_key_ff);

   always_comb begin
      countdown_in = countdown_ff;
      pend_all     = pend_key;
      if (req_s1.timer_tick && (idle_rate != 8'd0)) begin
         if (countdown_ff >= IDLE_STEP) begin
            countdown_in = countdown_ff - IDLE_STEP;
         end else begin
            countdown_in = idle_rate;
            pend_all     = 1'b1;
         end
      end
   end

   assign emit        = pend_all && req_s1.host_ready;
   assign pending_in  = pend_all && !req_s1.host_ready;
   assign last_key_in = key_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff  <= '0;
         pending_ff   <= 1'b0;
         countdown_ff <= '0;
      end else if (scan_commit) begin
         last_key_ff  <= last_key_in;
         pending_ff   <= pending_in;
         countdown_ff <= countdown_in;
      end
   end

   assign lay_ok    = (int'(layout_sel) >= 1) && (int'(layout_sel) <= LAYOUT_COUNT);
   assign map_wr_ok = (int'(req_s1.map_layout) < LAYOUT_COUNT) &&
                      (int'(req_s1.map_key) < KEY_COUNT);

   always_comb begin
      map_access.wr_en    = commit_en && (req_s1.func == FUNC_MAP_WRITE) && map_wr_ok;
      map_access.rd_en    = scan_commit;
      map_access.use_map  = (key_cur != '0) && lay_ok;
      map_access.wr_code  = req_s1.map_code;
      map_access.addr     = '0;
      map_access.alt_code = '0;
      if (req_s1.func == FUNC_MAP_WRITE) begin
         map_access.addr = MAP_ADDR_W'(int'(req_s1.map_layout) * KEY_COUNT +
                                       int'(req_s1.map_key));
      end else if (map_access.use_map) begin
         map_access.addr = MAP_ADDR_W'((int'(layout_sel) - 1) * KEY_COUNT +
                                       int'(key_cur) - 1);
      end
      if (key_cur == '0) begin
         map_access.alt_code = '0;
      end else if (!lay_ok) begin
         map_access.alt_code = FALLBACK_CODE;
      end else begin
         map_access.alt_code = default_code(int'(layout_sel) - 1, int'(key_cur) - 1);
      end
   end

endmodule

// ===== rtl/dkr_keymap.sv =====
// keymap memory with per-entry written bits over the default layouts
`timescale 1ns / 1ps
module dkr_keymap
   import dkr_pkg::*;
#(
   parameter int KEY_COUNT    = DEF_KEY_COUNT,
   parameter int LAYOUT_COUNT = DEF_LAYOUT_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  map_access_type    map_access,
   output logic [CODE_W-1:0] usage_code
);

   localparam int MAP_SIZE = KEY_COUNT * LAYOUT_COUNT;
   localparam int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;

   logic [CODE_W-1:0] map_mem [MAP_SIZE];
   logic [MAP_SIZE-1:0] map_valid_ff;
   logic [ADDR_W-1:0] addr;
   logic [CODE_W-1:0] rd_data_ff;
   logic [CODE_W-1:0] alt_code_ff;
   logic              hit_ff;

   assign addr = map_access.addr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (map_access.wr_en) begin
         map_mem[addr] <= map_access.wr_code;
      end
      if (map_access.rd_en) begin
         rd_data_ff  <= map_mem[addr];
         alt_code_ff <= map_access.alt_code;
         hit_ff      <= map_access.use_map && map_valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
      end else if (map_access.wr_en) begin
         map_valid_ff[addr] <= 1'b1;
      end
   end

   assign usage_code = hit_ff ? rd_data_ff : alt_code_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the debounced key scan reporter with its own report predictor
`timescale 1ns / 1ps
module testbench;
   import dkr_pkg::*;

   localparam int KEY_TOTAL      = DEF_KEY_COUNT;
   localparam int NUM_LAYOUTS    = DEF_LAYOUT_COUNT;
   localparam int SETTLE_COUNT   = DEF_DEBOUNCE_SAMPLES;
   localparam int REPEAT_STEP    = 5;
   localparam logic [7:0] UNMAPPED_CODE  = 8'd4;
   localparam logic [7:0] FIRST_KEY_CODE = 8'd30;
   localparam logic [7:0] SPARE_KEY_CODE = 8'd41;
   localparam logic [7:0] HOME_CODES [7] = '{8'd0, 8'd15, 8'd4, 8'd28, 8'd18, 8'd24, 8'd23};

   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 6;
   localparam int QUIET_LIMIT    = 500;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_SCANS    = 160;
   localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 50, 0, 26, 0, 50, 26, 0};
   localparam int PHASE_STALL     [NUM_PHASES] = '{0, 0, 50, 26, 0, 0, 26, 50};
   localparam int PHASE_IDLE_RATE [NUM_PHASES] = '{0, 255, 10, 1, 4, 5, 37, 0};
   localparam int PHASE_LAYOUT    [NUM_PHASES] = '{1, 4, 2, 3, 0, 7, 5, 1};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_IDLE_RATE;
   logic [7:0] csr_wdata = '0;

   req_type key_requests [$];
   rsp_type expected_reports [$];
   rsp_type predicted;
   rsp_type wanted;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      error_count = 0;
   int      quiet_cycles = 0;

   // predictor state
   logic [5:0] low_samples [KEY_TOTAL];
   logic [3:0] shown_key;
   logic       report_owed;
   logic [7:0] repeat_countdown;
   logic [7:0] keymap_copy [NUM_LAYOUTS*KEY_TOTAL];
   logic [7:0] idle_rate_copy;
   logic [2:0] layout_copy;

   debounced_key_scan_reporter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void reset_predictor();
      int l;
      int k;
      for (k = 0; k < KEY_TOTAL; k++) low_samples[k] = '0;
      shown_key = '0;
      report_owed = 1'b0;
      repeat_countdown = '0;
      idle_rate_copy = '0;
      layout_copy = 3'd1;
      for (l = 0; l < NUM_LAYOUTS; l++) begin
         for (k = 0; k < KEY_TOTAL; k++) begin
            if (k == 0) begin
               keymap_copy[l*KEY_TOTAL + k] = FIRST_KEY_CODE + 8'(l);
            end else if (k < 7) begin
               keymap_copy[l*KEY_TOTAL + k] = HOME_CODES[k];
            end else begin
               keymap_copy[l*KEY_TOTAL + k] = SPARE_KEY_CODE;
            end
         end
      end
   endfunction

   function automatic bit predict_report(input req_type r, output rsp_type rpt);
      int k;
      logic [3:0] cur;
      rpt = '0;
      if (r.func == FUNC_MAP_WRITE) begin
         if (int'(r.map_key) < KEY_TOTAL && int'(r.map_layout) < NUM_LAYOUTS) begin
            keymap_copy[int'(r.map_layout)*KEY_TOTAL + int'(r.map_key)] = r.map_code;
         end
         return 1'b0;
      end
      for (k = 0; k < KEY_TOTAL; k++) begin
         if (r.key_lines[k]) begin
            low_samples[k] = '0;
         end else if (int'(low_samples[k]) < SETTLE_COUNT) begin
            low_samples[k] = low_samples[k] + 6'd1;
         end
      end
      // keys 4 and up outrank keys 1 to 3
      cur = '0;
      for (k = 4; k <= KEY_TOTAL; k++) begin
         if (cur == 0 && int'(low_samples[k-1]) >= SETTLE_COUNT) cur = 4'(k);
      end
      for (k = 1; k <= 3; k++) begin
         if (cur == 0 && int'(low_samples[k-1]) >= SETTLE_COUNT) cur = 4'(k);
      end
      if (cur != shown_key) begin
         shown_key = cur;
         report_owed = 1'b1;
      end
      if (r.timer_tick && idle_rate_copy != 0) begin
         if (int'(repeat_countdown) >= REPEAT_STEP) begin
            repeat_countdown = repeat_countdown - 8'(REPEAT_STEP);
         end else begin
            repeat_countdown = idle_rate_copy;
            report_owed = 1'b1;
         end
      end
      if (report_owed && r.host_ready) begin
         report_owed = 1'b0;
         rpt.key_index = cur;
         if (cur == 0) begin
            rpt.usage_code = '0;
         end else if (layout_copy < 1 || int'(layout_copy) > NUM_LAYOUTS) begin
            rpt.usage_code = UNMAPPED_CODE;
         end else begin
            rpt.usage_code = keymap_copy[(int'(layout_copy) - 1)*KEY_TOTAL + int'(cur) - 1];
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic req_type scan_request(input logic [12:0] lines, input logic tick,
                                            input logic ready);
      req_type r;
      r.func       = FUNC_SCAN;
      r.key_lines  = lines;
      r.timer_tick = tick;
      r.host_ready = ready;
      r.map_layout = 2'($urandom_range(3, 0));
      r.map_key    = 4'($urandom_range(15, 0));
      r.map_code   = 8'($urandom_range(255, 0));
      return r;
   endfunction

   function automatic req_type map_request(input logic [1:0] layout, input logic [3:0] key,
                                           input logic [7:0] code);
      req_type r;
      r.func       = FUNC_MAP_WRITE;
      r.key_lines  = 13'($urandom_range(8191, 0));
      r.timer_tick = 1'($urandom_range(1, 0));
      r.host_ready = 1'($urandom_range(1, 0));
      r.map_layout = layout;
      r.map_key    = key;
      r.map_code   = code;
      return r;
   endfunction

   function automatic logic [12:0] pick_pattern();
      logic [12:0] lines;
      int choice;
      lines = '1;
      choice = $urandom_range(9, 0);
      if (choice == 0) begin
         lines = 13'($urandom_range(8191, 0));
      end else if (choice == 1) begin
         lines = '0;
      end else if (choice == 2) begin
         lines = '1;
      end else if (choice == 3) begin
         // only the low-priority keys
         repeat ($urandom_range(2, 1)) lines[$urandom_range(2, 0)] = 1'b0;
      end else begin
         repeat ($urandom_range(3, 1)) lines[$urandom_range(12, 0)] = 1'b0;
      end
      return lines;
   endfunction

   task automatic queue_random_scans(input int scan_target);
      int count;
      int hold;
      int j;
      logic [12:0] pattern;
      logic [12:0] lines;
      count = 0;
      while (count < scan_target) begin
         pattern = pick_pattern();
         // mostly holds long enough to settle, some broken short
         if ($urandom_range(4, 0) == 0) begin
            hold = $urandom_range(45, 1);
         end else begin
            hold = $urandom_range(60, SETTLE_COUNT);
         end
         for (j = 0; j < hold && count < scan_target; j++) begin
            lines = pattern;
            if ($urandom_range(79, 0) == 0) lines[$urandom_range(12, 0)] ^= 1'b1;
            if ($urandom_range(24, 0) == 0) begin
               key_requests.push_back(map_request(2'($urandom_range(3, 0)),
                                                  4'($urandom_range(15, 0)),
                                                  8'($urandom_range(255, 0))));
            end
            key_requests.push_back(scan_request(lines, $urandom_range(2, 0) == 0,
                                                $urandom_range(9, 0) < 7));
            count++;
         end
      end
   endtask

   task automatic wait_drained();
      while (key_requests.size() != 0 || req_valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IDLE_RATE) begin
         idle_rate_copy = value;
      end else begin
         layout_copy = value[2:0];
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         if (predict_report(req_data, predicted)) expected_reports.push_back(predicted);
      end
      if (!reset && (!req_valid || !req_stall)) begin
         if (key_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= key_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // report monitor
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report: key_index %0d, usage_code %0d",
                   rsp_data.key_index, rsp_data.usage_code);
            error_count++;
         end else begin
            wanted = expected_reports.pop_front();
            if (rsp_data.key_index !== wanted.key_index) begin
               $error("key_index mismatch: expected %0d, actual %0d",
                      wanted.key_index, rsp_data.key_index);
               error_count++;
            end
            if (rsp_data.usage_code !== wanted.usage_code) begin
               $error("usage_code mismatch: expected %0d, actual %0d",
                      wanted.usage_code, rsp_data.usage_code);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int p;
      reset_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests at reset settings
      key_requests.push_back(scan_request('1, 1'b1, 1'b1));
      key_requests.push_back(scan_request('0, 1'b0, 1'b0));
      key_requests.push_back(map_request(2'd0, 4'd0, 8'hff));
      key_requests.push_back(map_request(2'd3, 4'd12, 8'h00));
      // keymap writes past the last key are dropped
      key_requests.push_back(map_request(2'd0, 4'd13, 8'ha5));
      key_requests.push_back(map_request(2'd2, 4'd14, 8'h5a));
      key_requests.push_back(map_request(2'd3, 4'd15, 8'hc3));
      key_requests.push_back(map_request(2'd1, 4'd6, 8'h80));
      key_requests.push_back(scan_request(13'h1555, 1'b1, 1'b0));
      key_requests.push_back(scan_request(13'h0aaa, 1'b0, 1'b1));
      key_requests.push_back(scan_request('1, 1'b0, 1'b1));

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            wait_drained();
            write_register(CSR_IDLE_RATE, 8'(PHASE_IDLE_RATE[p]));
            write_register(CSR_LAYOUT_SEL,
                           {5'($urandom_range(31, 0)), 3'(PHASE_LAYOUT[p])});
         end
         send_idle_pct = PHASE_SEND_IDLE[p];
         stall_pct     = PHASE_STALL[p];
         queue_random_scans(PHASE_SCANS);
      end

      wait_drained();
      if (expected_reports.size() != 0) begin
         $error("%0d expected reports never arrived", expected_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dkr_pkg.sv
rtl/dkr_lane.sv
rtl/dkr_report.sv
rtl/dkr_keymap.sv
rtl/debounced_key_scan_reporter_unit.sv
tb/sv/testbench.sv
